// ----- rtl/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types, constants and helpers of the scheduled LED dimmer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sld_pkg;

  localparam int LIGHTS         = 8;
  localparam int SLOTS_PER_DAY  = 144;
  localparam int PWM_FULL_SCALE = 255;
  localparam int TABLE_DEPTH    = LIGHTS * SLOTS_PER_DAY;
  localparam int LIGHT_W        = $clog2(LIGHTS);
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);

  localparam logic [7:0] OFF_LIMIT     = 8'd50;
  localparam logic [7:0] MAX_PWM_LIMIT =
      (PWM_FULL_SCALE < 255) ? 8'(PWM_FULL_SCALE) : 8'd255;
  localparam logic [7:0] SLOT_LAST     = 8'(SLOTS_PER_DAY - 1);
  localparam logic [7:0] SLOT_COUNT    = 8'(SLOTS_PER_DAY);

  // floor(x / 100) = (x * RECIP_100) >> 23 for x < 2^16
  localparam logic [16:0] RECIP_100 = 17'd83887;
  // floor(y / 75) = (y * RECIP_75) >> 24 for y < 2^17
  localparam logic [17:0] RECIP_75  = 18'd223697;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_MANUAL = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] CFG_SCHED_EN = 2'd0;
  localparam logic [1:0] CFG_MAX_PWM  = 2'd1;
  localparam logic [1:0] CFG_MIN_PWM  = 2'd2;
  localparam logic [1:0] CFG_KICK     = 2'd3;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic mem_rd;
    logic rd_next;
    logic ld_p0;
    logic ld_p1;
    logic ld_cur;
    logic commit;
    logic load_second;
  } sld_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       sched_en;
    logic       clr_done;
    logic       kick;
  } sld_status_t;

  function automatic logic [2:0] div10(input logic [5:0] m);
    logic [2:0] d;
    if (m >= 6'd60) begin
      d = 3'd6;
    end else if (m >= 6'd50) begin
      d = 3'd5;
    end else if (m >= 6'd40) begin
      d = 3'd4;
    end else if (m >= 6'd30) begin
      d = 3'd3;
    end else if (m >= 6'd20) begin
      d = 3'd2;
    end else if (m >= 6'd10) begin
      d = 3'd1;
    end else begin
      d = 3'd0;
    end
    return d;
  endfunction

endpackage

// ----- rtl/sld_controller.sv -----
// ----------------------------------------------------------------------------
// sld_controller
// Sequencer: table clearing pass, per-request step schedule, result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sld_controller
  import sld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  sld_status_t status_i,
  output sld_cmd_t    cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  localparam logic [3:0] STEP_RD0      = 4'd0;
  localparam logic [3:0] STEP_RD1      = 4'd1;
  localparam logic [3:0] STEP_MAN_P0   = 4'd2;
  localparam logic [3:0] STEP_MAN_DONE = 4'd3;
  localparam logic [3:0] STEP_TICK_P0  = 4'd3;
  localparam logic [3:0] STEP_TICK_P1  = 4'd4;
  localparam logic [3:0] STEP_TICK_CUR = 4'd7;
  localparam logic [3:0] STEP_TICK_DON = 4'd8;

  logic [1:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       second_q, second_d;
  logic [3:0] done_step;
  logic       tick_go, manual_go, at_done, accept;

  assign tick_go   = (status_i.req == REQ_TICK) && status_i.sched_en;
  assign manual_go = (status_i.req == REQ_MANUAL) && !status_i.sched_en;

  always_comb begin
    case (status_i.req)
      REQ_TICK:   done_step = status_i.sched_en ? STEP_TICK_DON : STEP_RD0;
      REQ_MANUAL: done_step = status_i.sched_en ? STEP_RD0 : STEP_MAN_DONE;
      REQ_WRITE:  done_step = STEP_RD0;
      REQ_READ:   done_step = STEP_RD1;
      default:    done_step = STEP_RD0;
    endcase
  end

  assign at_done    = (state_q == S_RUN) && (step_q == done_step);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.capture     = accept;
    cmd_o.clr_wr      = (state_q == S_CLEAR);
    if (state_q == S_RUN) begin
      cmd_o.mem_rd  = (tick_go && (step_q == STEP_RD0 || step_q == STEP_RD1)) ||
                      ((status_i.req == REQ_READ) && step_q == STEP_RD0);
      cmd_o.rd_next = (step_q == STEP_RD1);
      cmd_o.ld_p0   = (tick_go && step_q == STEP_TICK_P0) ||
                      (manual_go && step_q == STEP_MAN_P0);
      cmd_o.ld_p1   = tick_go && step_q == STEP_TICK_P1;
      cmd_o.ld_cur  = tick_go && step_q == STEP_TICK_CUR;
      cmd_o.commit  = at_done && !out_valid_q;
    end
    cmd_o.load_second = out_valid_q && out_ready_i && second_q;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    second_d    = second_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          step_d  = STEP_RD0;
        end
      end
      S_RUN: begin
        if (!at_done) begin
          step_d = step_q + 4'd1;
        end else if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (out_valid_q && out_ready_i) begin
      if (second_q) begin
        second_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
      second_d    = status_i.kick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/sld_datapath.sv -----
// ----------------------------------------------------------------------------
// sld_datapath
// Schedule memory, percent-to-PWM and interpolation pipes, channel state,
// configuration registers and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sld_datapath
  import sld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic [1:0]         req_type_i,
  input  logic [LIGHT_W-1:0] light_index_i,
  input  logic [7:0]         level_pct_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  sld_cmd_t           cmd_i,
  output sld_status_t        status_o,
  output logic               pwm_write_o,
  output logic [LIGHT_W-1:0] out_light_o,
  output logic [7:0]         pwm_value_o,
  output logic               light_on_o,
  output logic               manual_rejected_o,
  output logic [7:0]         read_level_o,
  output logic               read_valid_o,
  output logic               last_o
);

  // configuration
  logic       sched_en_q;
  logic [7:0] max_q, min_q, kick_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_en_q <= 1'b0;
      max_q      <= MAX_PWM_LIMIT;
      min_q      <= 8'd0;
      kick_lvl_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCHED_EN: sched_en_q <= cfg_wdata_i[0];
        CFG_MAX_PWM:  max_q <= (cfg_wdata_i > MAX_PWM_LIMIT) ? MAX_PWM_LIMIT : cfg_wdata_i;
        CFG_MIN_PWM:  min_q <= cfg_wdata_i;
        CFG_KICK:     kick_lvl_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // request capture
  logic [1:0]         req_q;
  logic [LIGHT_W-1:0] light_q;
  logic [7:0]         level_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q, second_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      light_q  <= light_index_i;
      level_q  <= level_pct_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
    end
  end

  // slot addressing
  logic [2:0]        min_div;
  logic [3:0]        min_mod;
  logic [7:0]        slot_raw, slot, slot_nx;
  logic [ADDR_W-1:0] light_base, addr0, addr1;
  logic [9:0]        t_sec;
  logic              aligned;

  assign min_div    = div10(minute_q);
  assign min_mod    = 4'(minute_q - {min_div, 3'b0} - {2'b0, min_div, 1'b0});
  assign aligned    = (min_mod == 4'd0);
  assign slot_raw   = {1'b0, hour_q, 2'b0} + {2'b0, hour_q, 1'b0} + {5'b0, min_div};
  assign slot       = (slot_raw >= SLOT_COUNT) ? slot_raw - SLOT_COUNT : slot_raw;
  assign slot_nx    = (slot == SLOT_LAST) ? 8'd0 : slot + 8'd1;
  assign light_base = ADDR_W'({light_q, 7'b0}) + ADDR_W'({light_q, 4'b0});
  assign addr0      = light_base + ADDR_W'(slot);
  assign addr1      = light_base + ADDR_W'(slot_nx);
  assign t_sec      = {min_mod, 6'b0} - {4'b0, min_mod, 2'b0} + {4'b0, second_q};

  // schedule memory with clearing pass
  logic [7:0]        mem [TABLE_DEPTH];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] clr_cnt_q, wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;

  assign wr_en   = cmd_i.clr_wr || (cmd_i.commit && req_q == REQ_WRITE && aligned);
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : addr0;
  assign wr_data = cmd_i.clr_wr ? 8'd0 : level_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[cmd_i.rd_next ? addr1 : addr0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  // percent to PWM: min + trunc(pct * (max - min) / 100)
  logic [8:0]  span;
  logic [7:0]  span_mag, pct_sel;
  logic [15:0] map_prod_q;
  logic        map_neg_a_q, map_neg_b_q;
  logic [32:0] map_recip;
  logic [9:0]  map_quo_q;
  logic [11:0] p_next, p0_q, p1_q;

  assign span     = {1'b0, max_q} - {1'b0, min_q};
  assign span_mag = span[8] ? 8'(-span) : span[7:0];
  assign pct_sel  = (req_q == REQ_MANUAL) ? level_q : rdata_q;
  assign map_recip = {17'b0, map_prod_q} * {16'b0, RECIP_100};

  always_ff @(posedge clk_i) begin
    map_prod_q  <= {8'b0, pct_sel} * {8'b0, span_mag};
    map_neg_a_q <= span[8];
    map_quo_q   <= map_recip[32:23];
    map_neg_b_q <= map_neg_a_q;
  end

  assign p_next = map_neg_b_q ? {4'b0, min_q} - {2'b0, map_quo_q}
                              : {4'b0, min_q} + {2'b0, map_quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_p0) begin
      p0_q <= p_next;
    end
    if (cmd_i.ld_p1) begin
      p1_q <= p_next;
    end
  end

  // interpolation: p0 + floor((p1 - p0) * t / 600)
  logic signed [12:0] diff;
  logic signed [23:0] num_q, num_abs;
  logic [19:0]        mag, mag_q;
  logic [34:0]        div_prod;
  logic [10:0]        quo_q;
  logic               neg_q;
  logic [19:0]        quo600;
  logic [11:0]        quo_adj;
  logic [13:0]        cur, cur_q;

  assign diff     = $signed({p1_q[11], p1_q}) - $signed({p0_q[11], p0_q});
  assign num_abs  = num_q[23] ? -num_q : num_q;
  assign mag      = num_abs[19:0];
  assign div_prod = {18'b0, mag[19:3]} * {17'b0, RECIP_75};

  always_ff @(posedge clk_i) begin
    num_q <= diff * $signed({1'b0, t_sec});
    quo_q <= div_prod[34:24];
    mag_q <= mag;
    neg_q <= num_q[23];
  end

  assign quo600  = {quo_q, 9'b0} + {3'b0, quo_q, 6'b0} + {5'b0, quo_q, 4'b0}
                 + {6'b0, quo_q, 3'b0};
  assign quo_adj = {1'b0, quo_q} + {11'b0, (neg_q && quo600 != mag_q)};
  assign cur     = neg_q ? {{2{p0_q[11]}}, p0_q} - {2'b0, quo_adj}
                         : {{2{p0_q[11]}}, p0_q} + {2'b0, quo_adj};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_cur) begin
      cur_q <= cur;
    end
  end

  // channel drive
  logic [7:0]        drive_q [LIGHTS];
  logic [LIGHTS-1:0] on_q;
  logic [13:0]       v;
  logic [7:0]        vc, prev;
  logic              do_drive, rejected, is_full, is_off, kick, new_on;

  assign prev = drive_q[light_q];
  assign v    = (req_q == REQ_TICK) ? cur_q : {{2{p0_q[11]}}, p0_q};

  always_comb begin
    if (v[13]) begin
      vc = 8'd0;
    end else if (v > {6'b0, max_q}) begin
      vc = max_q;
    end else begin
      vc = v[7:0];
    end
  end

  assign is_full  = (vc >= max_q);
  assign is_off   = !is_full && (vc <= OFF_LIMIT);
  assign rejected = (req_q == REQ_MANUAL) && sched_en_q;
  assign do_drive = ((req_q == REQ_TICK) && sched_en_q && (cur_q != {6'b0, prev})) ||
                    ((req_q == REQ_MANUAL) && !sched_en_q);
  assign kick     = do_drive && !is_full && !is_off && (prev <= min_q);
  assign new_on   = do_drive ? !is_off : on_q[light_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIGHTS; i++) begin
        drive_q[i] <= 8'd0;
      end
      on_q <= '0;
    end else if (cmd_i.commit && do_drive) begin
      drive_q[light_q] <= is_full ? max_q : (is_off ? 8'd0 : vc);
      on_q[light_q]    <= !is_off;
    end
  end

  // result registers
  logic [7:0] second_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pwm_write_o       <= do_drive;
      out_light_o       <= light_q;
      pwm_value_o       <= !do_drive ? 8'd0 : kick ? kick_lvl_q :
                           is_full ? max_q : is_off ? 8'd0 : vc;
      light_on_o        <= new_on;
      manual_rejected_o <= rejected;
      read_level_o      <= (req_q == REQ_READ && aligned) ? rdata_q : 8'd0;
      read_valid_o      <= (req_q == REQ_READ || req_q == REQ_WRITE) && aligned;
      last_o            <= !kick;
      second_val_q      <= vc;
    end else if (cmd_i.load_second) begin
      pwm_value_o <= second_val_q;
      last_o      <= 1'b1;
    end
  end

  assign status_o.req      = req_q;
  assign status_o.sched_en = sched_en_q;
  assign status_o.clr_done = (clr_cnt_q == ADDR_W'(TABLE_DEPTH - 1));
  assign status_o.kick     = kick;

endmodule

// ----- rtl/scheduled_led_dimmer.sv -----
// ----------------------------------------------------------------------------
// scheduled_led_dimmer
// Eight-channel LED dimmer with a ten-minute day schedule per channel.
// ----------------------------------------------------------------------------
// A scheduled tick runs two table reads and the mapping and divide pipes
// before its first result, a manual level runs the mapping pipe, a table
// read needs one memory read; a table write or a no-op request needs none.
// One item is in flight at a time; the next is taken the cycle after commit.
// Reset: a pass clears all 1152 schedule entries, in_ready_o stays low.
`timescale 1ns / 1ps

module scheduled_led_dimmer
  import sld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [LIGHT_W-1:0] light_index_i,
  input  logic [7:0]         level_pct_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               pwm_write_o,
  output logic [LIGHT_W-1:0] out_light_o,
  output logic [7:0]         pwm_value_o,
  output logic               light_on_o,
  output logic               manual_rejected_o,
  output logic [7:0]         read_level_o,
  output logic               read_valid_o,
  output logic               last_o
);

  sld_cmd_t    cmd;
  sld_status_t status;

  sld_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sld_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_type_i),
    .light_index_i     (light_index_i),
    .level_pct_i       (level_pct_i),
    .hour_i            (hour_i),
    .minute_i          (minute_i),
    .second_i          (second_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .pwm_write_o       (pwm_write_o),
    .out_light_o       (out_light_o),
    .pwm_value_o       (pwm_value_o),
    .light_on_o        (light_on_o),
    .manual_rejected_o (manual_rejected_o),
    .read_level_o      (read_level_o),
    .read_valid_o      (read_valid_o),
    .last_o            (last_o)
  );

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !out_valid_o)
    else $error("result committed over a pending transaction");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (out_valid_o && last_o))
    else $error("kick write not followed by value write");

  a_kick_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> pwm_write_o)
    else $error("non-final result without pwm write");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !in_ready_o)
    else $error("input taken during table clearing");

endmodule

// ----- tb/tb_scheduled_led_dimmer.sv -----
// ----------------------------------------------------------------------------
// tb_scheduled_led_dimmer
// Self-checking bench for the scheduled LED dimmer. A behavioral copy of the
// dimmer (schedule table, per-light drive and on state, ramp interpolation,
// kick writes) predicts every result not given in the short directed table
// that comes first. Random phases follow, each with its own register setting.
// Handshakes idle at random; one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scheduled_led_dimmer;
  import sld_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_AFTER      = 150;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int IDLE_PCT        = 18;
  localparam int RAMP_SECONDS    = 600;
  localparam int DIRECTED_ROWS   = 24;

  typedef struct packed {
    logic [1:0]         req;
    logic [LIGHT_W-1:0] light;
    logic [7:0]         pct;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
  } dimmer_req_t;

  typedef struct packed {
    logic               wr;
    logic [LIGHT_W-1:0] light;
    logic [7:0]         val;
    logic               on;
    logic               rej;
    logic [7:0]         rl;
    logic               rv;
    logic               last;
  } dimmer_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         cfg_idx;
    logic [7:0]         cfg_val;
    logic [1:0]         req;
    logic [LIGHT_W-1:0] light;
    logic [7:0]         pct;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               typed;
    logic               e_wr;
    logic [7:0]         e_val;
    logic               e_on;
    logic               e_rej;
    logic [7:0]         e_rl;
    logic               e_rv;
  } row_t;

  // kind, cfg idx, cfg val, req, light, pct, hour, min, sec,
  // typed, wr, val, on, rej, read level, read valid
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_READ,   0,   0,  0,  0,  0, 1, 0,   0, 0, 0,   0, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_READ,   0,   0,  0,  5,  0, 1, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_WRITE,  0, 100,  0,  0,  0, 1, 0,   0, 0, 0,   0, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_WRITE,  0,  77,  0,  7,  0, 1, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_READ,   0,   0,  0,  0,  0, 1, 0,   0, 0, 0, 100, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_WRITE,  7, 255, 23, 50,  0, 1, 0,   0, 0, 0,   0, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_READ,   7,   0, 23, 50,  0, 1, 0,   0, 0, 0, 255, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_WRITE,  3,  90, 31, 60,  0, 1, 0,   0, 0, 0,   0, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_READ,   3,   0,  8,  0,  0, 1, 0,   0, 0, 0,  90, 1},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 1, 100,  0,  0,  0, 1, 1, 255, 1, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 1,   0,  0,  0,  0, 1, 1,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 2,  50,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 2,  60,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 2,  20,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 2,  19,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 4, 255,  0,  0,  0, 1, 1, 255, 1, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_TICK,   4,   0,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_CFG,  CFG_SCHED_EN, 1, REQ_TICK,   0,   0,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_MANUAL, 0,  80,  0,  0,  0, 1, 0,   0, 0, 1,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_TICK,   0,   0,  0,  0,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_TICK,   0,   0,  0,  5,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_TICK,   0,   0,  0,  9, 63, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_TICK,   7,   0, 23, 50,  0, 0, 0,   0, 0, 0,   0, 0},
    '{ROW_ITEM, CFG_SCHED_EN, 0, REQ_TICK,   5,   0, 31, 63, 63, 0, 0,   0, 0, 0,   0, 0}
  };

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [1:0]         cfg_index   = '0;
  logic [7:0]         cfg_wdata   = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type    = '0;
  logic [LIGHT_W-1:0] light_index = '0;
  logic [7:0]         level_pct   = '0;
  logic [4:0]         hour        = '0;
  logic [5:0]         minute      = '0;
  logic [5:0]         second      = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               pwm_write;
  logic [LIGHT_W-1:0] out_light;
  logic [7:0]         pwm_value;
  logic               light_on;
  logic               manual_rejected;
  logic [7:0]         read_level;
  logic               read_valid;
  logic               last;

  // Predictor state
  logic [7:0] sched_tbl [LIGHTS*SLOTS_PER_DAY];
  logic [7:0] drive_lvl [LIGHTS];
  logic       light_lit [LIGHTS];
  logic       sched_en_m;
  logic [7:0] max_m;
  logic [7:0] min_m;
  logic [7:0] kick_m;

  dimmer_result_t dimmer_results_q [$];
  dimmer_result_t oldest;
  int unsigned    mismatches   = 0;
  int unsigned    results_seen = 0;
  int unsigned    idle_cycles  = 0;
  int unsigned    hold_left    = 0;
  logic           hold_done    = 1'b0;
  logic           quiet        = 1'b0;

  scheduled_led_dimmer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .light_index_i     (light_index),
    .level_pct_i       (level_pct),
    .hour_i            (hour),
    .minute_i          (minute),
    .second_i          (second),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .pwm_write_o       (pwm_write),
    .out_light_o       (out_light),
    .pwm_value_o       (pwm_value),
    .light_on_o        (light_on),
    .manual_rejected_o (manual_rejected),
    .read_level_o      (read_level),
    .read_valid_o      (read_valid),
    .last_o            (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pct_to_drive(input logic [7:0] pct);
    return (int'(pct) * (int'(max_m) - int'(min_m))) / 100 + int'(min_m);
  endfunction

  task automatic dimmer_step(input dimmer_req_t r);
    int             base;
    int             slot;
    int             p0;
    int             p1;
    int             t;
    int             num;
    int             q;
    int             cur;
    int             v;
    logic           do_drive;
    logic           kick;
    logic           aligned;
    dimmer_result_t res;
    base     = int'(r.light) * SLOTS_PER_DAY;
    slot     = (int'(r.hour) * 6 + int'(r.minute) / 10) % SLOTS_PER_DAY;
    aligned  = (int'(r.minute) % 10) == 0;
    do_drive = 1'b0;
    kick     = 1'b0;
    v        = 0;
    res      = '0;
    res.light = r.light;
    res.last  = 1'b1;
    case (r.req)
      REQ_TICK: begin
        if (sched_en_m) begin
          p0  = pct_to_drive(sched_tbl[base + slot]);
          p1  = pct_to_drive(sched_tbl[base + (slot + 1) % SLOTS_PER_DAY]);
          t   = (int'(r.minute) % 10) * 60 + int'(r.second);
          num = (p1 - p0) * t;
          q   = num / RAMP_SECONDS;
          if (num % RAMP_SECONDS != 0 && num < 0) q = q - 1;
          cur = p0 + q;
          if (cur != int'(drive_lvl[r.light])) begin
            do_drive = 1'b1;
            v        = cur;
          end
        end
      end
      REQ_MANUAL: begin
        if (sched_en_m) begin
          res.rej = 1'b1;
        end else begin
          do_drive = 1'b1;
          v        = pct_to_drive(r.pct);
        end
      end
      REQ_WRITE: begin
        if (aligned) sched_tbl[base + slot] = r.pct;
        res.rv = aligned;
      end
      default: begin
        res.rv = aligned;
        res.rl = aligned ? sched_tbl[base + slot] : 8'd0;
      end
    endcase
    if (do_drive) begin
      if (v < 0) v = 0;
      if (v > int'(max_m)) v = int'(max_m);
      res.wr = 1'b1;
      if (v >= int'(max_m)) begin
        drive_lvl[r.light] = max_m;
        light_lit[r.light] = 1'b1;
      end else if (v <= int'(OFF_LIMIT)) begin
        drive_lvl[r.light] = 8'd0;
        light_lit[r.light] = 1'b0;
      end else begin
        kick               = drive_lvl[r.light] <= min_m;
        drive_lvl[r.light] = 8'(v);
        light_lit[r.light] = 1'b1;
      end
      res.on = light_lit[r.light];
      if (kick) begin
        res.val  = kick_m;
        res.last = 1'b0;
        dimmer_results_q.push_back(res);
        res.last = 1'b1;
      end
      res.val = drive_lvl[r.light];
    end else begin
      res.on = light_lit[r.light];
    end
    dimmer_results_q.push_back(res);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SCHED_EN: sched_en_m = data[0];
      CFG_MAX_PWM:  max_m = (int'(data) > PWM_FULL_SCALE) ? 8'(PWM_FULL_SCALE) : data;
      CFG_MIN_PWM:  min_m = data;
      CFG_KICK:     kick_m = data;
      default: ;
    endcase
  endtask

  task automatic send_item(input dimmer_req_t it);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid    <= 1'b1;
    req_type    <= it.req;
    light_index <= it.light;
    level_pct   <= it.pct;
    hour        <= it.hour;
    minute      <= it.minute;
    second      <= it.second;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (dimmer_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    dimmer_req_t    it;
    dimmer_result_t typed_res;
    row_t           row;
    int             n_before;
    int             roll;
    logic           en;
    logic [7:0]     mx;
    logic [7:0]     mn;
    logic [7:0]     kk;
    for (int i = 0; i < LIGHTS * SLOTS_PER_DAY; i++) sched_tbl[i] = '0;
    for (int i = 0; i < LIGHTS; i++) begin
      drive_lvl[i] = '0;
      light_lit[i] = 1'b0;
    end
    sched_en_m = 1'b0;
    max_m      = MAX_PWM_LIMIT;
    min_m      = 8'd0;
    kick_m     = 8'd255;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.cfg_idx, row.cfg_val);
        cfg_we <= 1'b0;
      end else begin
        it.req    = row.req;
        it.light  = row.light;
        it.pct    = row.pct;
        it.hour   = row.hour;
        it.minute = row.minute;
        it.second = row.second;
        send_item(it);
        n_before = dimmer_results_q.size();
        dimmer_step(it);
        if (row.typed) begin
          while (dimmer_results_q.size() > n_before) void'(dimmer_results_q.pop_back());
          typed_res.wr    = row.e_wr;
          typed_res.light = row.light;
          typed_res.val   = row.e_val;
          typed_res.on    = row.e_on;
          typed_res.rej   = row.e_rej;
          typed_res.rl    = row.e_rl;
          typed_res.rv    = row.e_rv;
          typed_res.last  = 1'b1;
          dimmer_results_q.push_back(typed_res);
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin en = 1'b1; mx = 8'd255; mn = 8'd0;   kk = 8'd255; end
        1: begin en = 1'b0; mx = 8'd0;   mn = 8'd0;   kk = 8'd0;   end
        2: begin en = 1'b1; mx = 8'd255; mn = 8'd255; kk = 8'd255; end
        3: begin en = 1'b0; mx = 8'd100; mn = 8'd200; kk = 8'd128; end
        default: begin
          en = ph[0];
          mx = 8'($urandom_range(120, 255));
          mn = 8'($urandom_range(0, 100));
          kk = 8'($urandom_range(0, 255));
        end
      endcase
      quiet <= (ph == 4);
      write_reg(CFG_SCHED_EN, {7'($urandom_range(0, 127)), en});
      write_reg(CFG_MAX_PWM, mx);
      write_reg(CFG_MIN_PWM, mn);
      write_reg(CFG_KICK, kk);
      cfg_we <= 1'b0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        roll   = $urandom_range(0, 99);
        it.req = (roll < 40) ? REQ_TICK : (roll < 60) ? REQ_MANUAL :
                 (roll < 85) ? REQ_WRITE : REQ_READ;
        it.light = LIGHT_W'($urandom_range(0, LIGHTS - 1));
        it.pct   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 100));
        if ($urandom_range(0, 19) == 0) begin
          // anything the fields can carry, wrap and extrapolation included
          it.hour   = 5'($urandom_range(0, 31));
          it.minute = 6'($urandom_range(0, 63));
          it.second = 6'($urandom_range(0, 63));
        end else begin
          // mostly hours 0-2, so ticks land on slots that writes have filled
          it.hour   = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 2))
                                                  : 5'($urandom_range(0, 23));
          it.minute = (it.req != REQ_TICK && $urandom_range(0, 4) != 0)
                      ? 6'(10 * $urandom_range(0, 5)) : 6'($urandom_range(0, 59));
          it.second = 6'($urandom_range(0, 59));
        end
        send_item(it);
        dimmer_step(it);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("** scheduled_led_dimmer: PASSED **");
    end else begin
      $display("** scheduled_led_dimmer: FAILED **");
    end
    $finish;
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (dimmer_results_q.size() == 0) begin
        $error("result transaction with nothing pending, light %0d", out_light);
        mismatches++;
      end else begin
        oldest = dimmer_results_q.pop_front();
        check_field("pwm_write", oldest.wr, pwm_write);
        check_field("out_light", oldest.light, out_light);
        check_field("pwm_value", oldest.val, pwm_value);
        check_field("light_on", oldest.on, light_on);
        check_field("manual_rejected", oldest.rej, manual_rejected);
        check_field("read_level", oldest.rl, read_level);
        check_field("read_valid", oldest.rv, read_valid);
        check_field("last", oldest.last, last);
      end
    end
  end

  // Result side: random stalls plus one long hold-off that backs up the input
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** scheduled_led_dimmer: FAILED **");
      $finish;
    end
  end

endmodule
